// ===== hdl/json_key_value_extractor_core_defines.svh =====
// ----------------------------------------------------------------------------
// JSON key/value extractor: assertion macros
// Concurrent checks clocked on a rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_CORE_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define JKV_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jkv check failed");
// Next-cycle implication
`define JKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jkv check failed");
`else
`define JKV_ASSERT(lbl, clk, rstn, ante, cons)
`define JKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/jkv_pkg.sv =====
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types, constants and character classes of the JSON key/value
// extractor.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int DEF_MAX_KEY_BYTES   = 16;
    localparam int DEF_MAX_VALUE_BYTES = 63;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int KLEN_W    = 5;
    localparam int LEN_W     = 7;
    localparam int CFG_A_W   = 2;
    localparam int CFG_D_W   = 64;
    localparam int KEY_W     = 128;

    // characters
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_BUF_LEN  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_PRE_COLON,
        PH_POST_COLON,
        PH_QUOTED,
        PH_BARE,
        PH_DONE,
        PH_FAILED
    } t_phase;

    typedef enum logic [1:0] {
        EM_RUN,
        EM_DRAIN,
        EM_FINAL
    } t_emit_state;

    // end-of-document report from scanner to emitter
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [LEN_W-1:0] count;
    } t_doc_end;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_stop(input logic [7:0] b);
        return is_blank(b) || (b == CH_COMMA) || (b == CH_LBRACE) ||
               (b == CH_RBRACE) || (b == CH_LBRACK) || (b == CH_RBRACK);
    endfunction

endpackage

// ===== hdl/jkv_store.sv =====
// ----------------------------------------------------------------------------
// jkv_store
// Value byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jkv_store
    import jkv_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_VALUE_BYTES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/jkv_scan.sv =====
// ----------------------------------------------------------------------------
// jkv_scan
// Key search over a sliding byte window, colon check and value capture.
// ----------------------------------------------------------------------------
module jkv_scan
    import jkv_pkg::*;
#(
    parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
    parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES,
    parameter int AW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [KLEN_W-1:0] i_key_len,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output t_doc_end          o_end
);

    localparam int SW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KLEN_W-1:0] KMAX    = KLEN_W'(MAX_KEY_BYTES);
    localparam logic [SW-1:0]     SEENMAX = SW'(MAX_KEY_BYTES);
    localparam logic [LEN_W-1:0]  LEN_CAP = LEN_W'(MAX_VALUE_BYTES + 1);
    localparam logic [LEN_W-1:0]  STORE_N = LEN_W'(MAX_VALUE_BYTES);

    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_win [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]  n_win [MAX_KEY_BYTES];
    logic [SW-1:0]      r_seen, n_seen;
    logic [LEN_W-1:0]   r_count, n_count;

    logic [KLEN_W-1:0]  key_k;
    t_phase             cur_phase;
    logic               key_hit;
    logic               do_cap;

    // effective key length
    assign key_k = (i_key_len > KMAX) ? KMAX : i_key_len;

    // an empty key matches before any byte
    assign cur_phase = (r_phase == PH_SEARCH && key_k == '0) ? PH_PRE_COLON : r_phase;

    // shifted window and key compare
    always_comb begin
        logic [KLEN_W-1:0] pos;
        logic [SW-1:0]     seen_inc;
        n_win[0] = i_byte;
        for (int j = 1; j < MAX_KEY_BYTES; j++) begin
            n_win[j] = r_win[j-1];
        end
        seen_inc = (r_seen == SEENMAX) ? r_seen : r_seen + SW'(1);
        key_hit  = (KLEN_W'(seen_inc) >= key_k);
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            pos = key_k - KLEN_W'(1) - KLEN_W'(i);
            if (KLEN_W'(i) < key_k) begin
                if (n_win[pos[KIW-1:0]] != i_key[8*i +: 8]) begin
                    key_hit = 1'b0;
                end
            end
        end
    end

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_count = r_count;
        do_cap  = 1'b0;
        if (i_byte_valid) begin
            n_phase = cur_phase;
            if (i_byte == '0) begin
                n_phase = PH_SEARCH;
                n_seen  = '0;
                n_count = '0;
            end else begin
                unique case (cur_phase)
                    PH_SEARCH: begin
                        n_seen = (r_seen == SEENMAX) ? r_seen : r_seen + SW'(1);
                        if (key_hit) begin
                            n_phase = PH_PRE_COLON;
                        end
                    end
                    PH_PRE_COLON: begin
                        if (!is_blank(i_byte)) begin
                            n_phase = (i_byte == CH_COLON) ? PH_POST_COLON : PH_FAILED;
                        end
                    end
                    PH_POST_COLON: begin
                        if (is_blank(i_byte)) begin
                            n_phase = PH_POST_COLON;
                        end else if (i_byte == CH_QUOTE) begin
                            n_phase = PH_QUOTED;
                        end else if (is_stop(i_byte)) begin
                            n_phase = PH_DONE;
                        end else begin
                            do_cap  = 1'b1;
                            n_phase = PH_BARE;
                        end
                    end
                    PH_QUOTED: begin
                        if (i_byte == CH_QUOTE) begin
                            n_phase = PH_DONE;
                        end else begin
                            do_cap = 1'b1;
                        end
                    end
                    PH_BARE: begin
                        if (is_stop(i_byte)) begin
                            n_phase = PH_DONE;
                        end else begin
                            do_cap = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = cur_phase;
                    end
                endcase
                if (do_cap && r_count < LEN_CAP) begin
                    n_count = r_count + LEN_W'(1);
                end
            end
        end
    end

    // value memory write
    assign o_wr_en   = do_cap && (r_count < STORE_N);
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = i_byte;

    // end-of-document report
    assign o_end.valid = i_byte_valid && (i_byte == '0);
    assign o_end.found = (cur_phase == PH_POST_COLON) || (cur_phase == PH_QUOTED) ||
                         (cur_phase == PH_BARE) || (cur_phase == PH_DONE);
    assign o_end.count = r_count;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_seen  <= '0;
            r_count <= '0;
            for (int j = 0; j < MAX_KEY_BYTES; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_count <= n_count;
            if (i_byte_valid && i_byte == '0) begin
                for (int j = 0; j < MAX_KEY_BYTES; j++) begin
                    r_win[j] <= '0;
                end
            end else if (i_byte_valid && cur_phase == PH_SEARCH) begin
                for (int j = 0; j < MAX_KEY_BYTES; j++) begin
                    r_win[j] <= n_win[j];
                end
            end
        end
    end

endmodule

// ===== hdl/jkv_emit.sv =====
// ----------------------------------------------------------------------------
// jkv_emit
// Drains captured value bytes from memory and issues the final status item
// through an output register.
// ----------------------------------------------------------------------------
`include "json_key_value_extractor_core_defines.svh"

module jkv_emit
    import jkv_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES,
    parameter int AW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_doc_end          i_end,
    input  logic [LEN_W-1:0]  i_buf_len,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic [AW-1:0]     o_rd_addr,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    output t_status           o_status,
    output logic [LEN_W-1:0]  o_len
);

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_VALUE_BYTES + 1);

    t_emit_state        r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    t_status            r_fin_status, n_fin_status;
    logic [LEN_W-1:0]   r_fin_len, n_fin_len;

    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    t_status            r_status;
    logic [LEN_W-1:0]   r_len;

    logic [LEN_W-1:0]   lim;
    logic               slot_free;
    logic               load_val;
    logic               load_fin;
    logic               idx_last;
    logic               end_drain;

    assign lim       = (i_buf_len > LEN_CAP) ? LEN_CAP : i_buf_len;
    assign slot_free = !r_valid || i_ready;
    assign idx_last  = (LEN_W'(r_idx) + LEN_W'(1) == r_fin_len);
    assign end_drain = i_end.found && (i_end.count < lim) && (i_end.count != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EM_RUN: begin
                if (i_end.valid) begin
                    n_state = end_drain ? EM_DRAIN : EM_FINAL;
                end
            end
            EM_DRAIN: begin
                if (load_val && idx_last) begin
                    n_state = EM_FINAL;
                end
            end
            EM_FINAL: begin
                if (load_fin) begin
                    n_state = EM_RUN;
                end
            end
            default: begin
                n_state = EM_RUN;
            end
        endcase
    end

    // state outputs and datapath controls
    always_comb begin
        o_in_ready   = (r_state == EM_RUN);
        load_val     = (r_state == EM_DRAIN) && slot_free;
        load_fin     = (r_state == EM_FINAL) && slot_free;
        n_idx        = r_idx;
        n_fin_status = r_fin_status;
        n_fin_len    = r_fin_len;
        if (r_state == EM_RUN) begin
            n_idx = '0;
            if (i_end.valid) begin
                if (!i_end.found) begin
                    n_fin_status = ST_NOT_FOUND;
                    n_fin_len    = '0;
                end else if (i_end.count < lim) begin
                    n_fin_status = ST_FOUND;
                    n_fin_len    = i_end.count;
                end else begin
                    n_fin_status = ST_TOO_LONG;
                    n_fin_len    = i_end.count;
                end
            end
        end else if (load_val) begin
            n_idx = idx_last ? '0 : r_idx + AW'(1);
        end
    end

    // read address runs one ahead so the registered data matches r_idx
    assign o_rd_addr = n_idx;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_RUN;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_val || load_fin) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fin_status <= n_fin_status;
        r_fin_len    <= n_fin_len;
        if (load_val) begin
            r_byte   <= i_rd_data;
            r_last   <= 1'b0;
            r_status <= ST_FOUND;
            r_len    <= '0;
        end else if (load_fin) begin
            r_byte   <= '0;
            r_last   <= 1'b1;
            r_status <= r_fin_status;
            r_len    <= r_fin_len;
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;
    assign o_status = r_status;
    assign o_len    = r_len;

    // checks
    `JKV_ASSERT(a_end_in_run, i_clk, i_rst_n, i_end.valid, r_state == EM_RUN)
    `JKV_ASSERT(a_drain_in_range, i_clk, i_rst_n, r_state == EM_DRAIN, LEN_W'(r_idx) < r_fin_len)
    `JKV_ASSERT(a_value_item_clean, i_clk, i_rst_n, r_valid && !r_last, r_status == ST_FOUND && r_len == '0)
    `JKV_ASSERT(a_final_zero_byte, i_clk, i_rst_n, r_valid && r_last, r_byte == '0)
    `JKV_ASSERT_NEXT(a_drain_entry, i_clk, i_rst_n, i_end.valid && end_drain, r_state == EM_DRAIN && r_idx == '0)

endmodule

// ===== hdl/json_key_value_extractor_core.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor_core
// Scans a JSON byte stream for a configured key and returns its value bytes
// followed by a final status item at each end of document.
//
//  channel   dir  handshake                    payload
//  s_axis    in   tvalid/tready                tdata[7:0] in_byte
//  m_axis    out  tvalid/tready                tdata: out_byte, value_length;
//                                              tlast: last; tuser: status
//  cfg       in   we (no wait)                 addr = register index, wdata
//
// The block takes one nonzero byte per cycle while s_axis_tready is high.
// After a zero byte it holds s_axis_tready low while it drains the stored
// value bytes from the value memory read port, one per cycle when m_axis does
// not stall (only when the key was found and the value is nonempty and fits
// the buffer), then issues the status item. Reset is synchronous and needs no
// clearing pass; the block can take a byte as soon as reset is released.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core
    import jkv_pkg::*;
#(
    parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
    parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata,   // [7:0] out_byte, [14:8] value_length
    output logic               o_m_axis_tlast,
    output logic [1:0]         o_m_axis_tuser    // [1:0] status
);

    localparam int AW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;

    logic [CFG_D_W-1:0] r_key_low;
    logic [CFG_D_W-1:0] r_key_high;
    logic [KLEN_W-1:0]  r_key_len;
    logic [LEN_W-1:0]   r_buf_len;

    logic               byte_valid;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic [AW-1:0]      rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    t_doc_end           doc_end;
    logic               in_ready;
    logic [BYTE_W-1:0]  out_byte;
    t_status            out_status;
    logic [LEN_W-1:0]   out_len;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KLEN_W'(1);
            r_buf_len  <= LEN_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                CFG_KEY_LEN:  r_key_len  <= i_cfg_wdata[KLEN_W-1:0];
                CFG_BUF_LEN:  r_buf_len  <= i_cfg_wdata[LEN_W-1:0];
                default:      r_key_len  <= r_key_len;
            endcase
        end
    end

    assign byte_valid      = i_s_axis_tvalid && in_ready;
    assign o_s_axis_tready = in_ready;

    jkv_scan #(
        .MAX_KEY_BYTES   (MAX_KEY_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .AW              (AW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (i_s_axis_tdata),
        .i_key        ({r_key_high, r_key_low}),
        .i_key_len    (r_key_len),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_end        (doc_end)
    );

    jkv_store #(
        .DEPTH (MAX_VALUE_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    jkv_emit #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .AW              (AW)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_end      (doc_end),
        .i_buf_len  (r_buf_len),
        .i_rd_data  (rd_data),
        .o_rd_addr  (rd_addr),
        .o_in_ready (in_ready),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_byte     (out_byte),
        .o_last     (o_m_axis_tlast),
        .o_status   (out_status),
        .o_len      (out_len)
    );

    // output packing
    assign o_m_axis_tdata = {1'b0, out_len, out_byte};
    assign o_m_axis_tuser = out_status;

endmodule

// ===== tb/sv/json_key_value_extractor_core_tb.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor_core_tb
// Self-checking bench for the JSON key/value extractor. A scoreboard class
// tracks the scan state, predicts the value items and the status item
// produced at each end of document, and compares every output item field by
// field. Directed documents cover the corner cases; random documents, mostly
// well formed, run under changing key and buffer settings with bursty input
// and random or periodic output back-pressure.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core_tb;
    import jkv_pkg::*;

    // one output item as predicted
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        t_status    status;
        logic [6:0] value_length;
    } t_extract_item;

    // scan-state tracker and expected-item store
    class extract_checker;
        logic [63:0]   key_lo;
        logic [63:0]   key_hi;
        logic [4:0]    key_len;
        logic [6:0]    buf_len;
        t_phase        phase;
        logic [7:0]    window [16];
        int            seen;
        logic [7:0]    value_mem [63];
        int            value_cnt;
        t_extract_item expected_items [$];
        int            errors;

        function new();
            key_lo    = '0;
            key_hi    = '0;
            key_len   = 5'd1;
            buf_len   = 7'd64;
            errors    = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            phase = PH_SEARCH;
            foreach (window[i]) window[i] = 8'h00;
            seen      = 0;
            value_cnt = 0;
        endfunction

        function logic [7:0] key_at(int i);
            if (i < 8) return key_lo[8*i +: 8];
            return key_hi[8*(i-8) +: 8];
        endfunction

        // number of key bytes actually compared
        function int key_span();
            return (key_len > 5'd16) ? 16 : int'(key_len);
        endfunction

        function bit blank_char(logic [7:0] b);
            return (b == CH_SPACE) || (b == CH_TAB);
        endfunction

        function bit value_end(logic [7:0] b);
            return blank_char(b) || (b == CH_COMMA) || (b == CH_LBRACE) ||
                   (b == CH_RBRACE) || (b == CH_LBRACK) || (b == CH_RBRACK);
        endfunction

        function void set_reg(t_cfg_reg r, logic [63:0] v);
            case (r)
                CFG_KEY_LOW:  key_lo  = v;
                CFG_KEY_HIGH: key_hi  = v;
                CFG_KEY_LEN:  key_len = v[4:0];
                CFG_BUF_LEN:  buf_len = v[6:0];
                default: ;
            endcase
        endfunction

        function void push_item(logic [7:0] b, logic lst, t_status st, int len);
            t_extract_item e;
            e.out_byte     = b;
            e.last         = lst;
            e.status       = st;
            e.value_length = len[6:0];
            expected_items.push_back(e);
        endfunction

        function void capture(logic [7:0] b);
            if (value_cnt < 63) value_mem[value_cnt] = b;
            if (value_cnt < 64) value_cnt++;
        endfunction

        // note one accepted document byte
        function void take_byte(logic [7:0] b);
            int k;
            int lim;
            bit hit;
            k = key_span();
            if (phase == PH_SEARCH && k == 0) phase = PH_PRE_COLON;

            // end of document: predict the value bytes (when found and short enough) and the status item
            if (b == 8'h00) begin
                if (phase == PH_POST_COLON || phase == PH_QUOTED ||
                        phase == PH_BARE || phase == PH_DONE) begin
                    lim = (buf_len > 7'd64) ? 64 : int'(buf_len);
                    if (value_cnt < lim) begin
                        for (int i = 0; i < value_cnt; i++)
                            push_item(value_mem[i], 1'b0, ST_FOUND, 0);
                        push_item(8'h00, 1'b1, ST_FOUND, value_cnt);
                    end else begin
                        push_item(8'h00, 1'b1, ST_TOO_LONG, value_cnt);
                    end
                end else begin
                    push_item(8'h00, 1'b1, ST_NOT_FOUND, 0);
                end
                clear_doc();
                return;
            end

            case (phase)
                PH_SEARCH: begin
                    for (int i = 15; i > 0; i--) window[i] = window[i-1];
                    window[0] = b;
                    if (seen < 16) seen++;
                    hit = (seen >= k);
                    for (int i = 0; i < k; i++)
                        if (window[k-1-i] != key_at(i)) hit = 1'b0;
                    if (hit) phase = PH_PRE_COLON;
                end
                PH_PRE_COLON: begin
                    if (!blank_char(b)) begin
                        if (b == CH_COLON) phase = PH_POST_COLON;
                        else phase = PH_FAILED;
                    end
                end
                PH_POST_COLON: begin
                    if (b == CH_QUOTE) begin
                        phase = PH_QUOTED;
                    end else if (value_end(b)) begin
                        if (!blank_char(b)) phase = PH_DONE;
                    end else begin
                        capture(b);
                        phase = PH_BARE;
                    end
                end
                PH_QUOTED: begin
                    if (b == CH_QUOTE) phase = PH_DONE;
                    else capture(b);
                end
                PH_BARE: begin
                    if (value_end(b)) phase = PH_DONE;
                    else capture(b);
                end
                default: ;
            endcase
        endfunction

        // compare one accepted output item with the oldest expectation
        function void check_item(logic [7:0] ob, logic lst, logic [1:0] st,
                                 logic [6:0] len);
            t_extract_item e;
            if (expected_items.size() == 0) begin
                $error("unexpected item: out_byte %0h last %0b status %0d length %0d",
                       ob, lst, st, len);
                errors++;
                return;
            end
            e = expected_items.pop_front();
            if (ob !== e.out_byte) begin
                $error("out_byte: expected %0h, got %0h", e.out_byte, ob);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, lst);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (len !== e.value_length) begin
                $error("value_length: expected %0d, got %0d", e.value_length, len);
                errors++;
            end
        endfunction

        function int pending();
            return expected_items.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_A_W-1:0]  i_cfg_addr;
    logic [CFG_D_W-1:0]  i_cfg_wdata;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [15:0]         o_m_axis_tdata;
    logic                o_m_axis_tlast;
    logic [1:0]          o_m_axis_tuser;

    extract_checker      sb;
    logic [7:0]          doc_q [$];
    int                  burst_left;
    int                  n_doc_bytes;
    int                  stall_mode;
    logic [7:0]          stall_tick;
    logic [7:0]          stop_chars [7] = '{CH_SPACE, CH_TAB, CH_COMMA, CH_LBRACE,
                                           CH_RBRACE, CH_LBRACK, CH_RBRACK};

    json_key_value_extractor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // output back-pressure
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_axis_tready <= (stall_tick[2:0] != 3'd0);
            default: i_m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // handshake monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.take_byte(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_item(o_m_axis_tdata[7:0], o_m_axis_tlast, o_m_axis_tuser,
                          o_m_axis_tdata[14:8]);
    end

    // present one byte, hold until taken, then maybe gap
    task send_byte(input logic [7:0] b);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_doc_bytes++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task send_doc_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(8'h00);
    endtask

    task send_doc();
        foreach (doc_q[i]) send_byte(doc_q[i]);
        send_byte(8'h00);
    endtask

    task idle_sender();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // wait until every predicted item is out, then let the block settle
    task wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all four registers; block must be idle
    task configure(input logic [63:0] lo, input logic [63:0] hi,
                   input int klen, input int blen);
        logic [63:0] v [4];
        t_cfg_reg    r;
        v[0] = lo;
        v[1] = hi;
        v[2] = 64'(klen);
        v[3] = 64'(blen);
        for (int i = 0; i < 4; i++) begin
            r = t_cfg_reg'(i);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= r;
            i_cfg_wdata <= v[i];
            @(posedge i_clk);
            sb.set_reg(r, v[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return CH_COLON;
            1: return CH_SPACE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // value byte that does not end the value early
    function logic [7:0] value_byte(bit quoted);
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_QUOTE) b = quoted ? 8'h71 : 8'h62;
        else if (!quoted && sb.value_end(b)) b = 8'h62;
        return b;
    endfunction

    // build one document in doc_q; vlen < 0 picks a random shape
    task build_doc(input int vlen);
        int  kind;
        int  k;
        bit  quoted;
        doc_q.delete();
        kind = (vlen >= 0) ? 2 : $urandom_range(0, 9);

        // noise
        if (kind == 0) begin
            repeat ($urandom_range(0, 8)) doc_q.push_back(noise_byte());
            return;
        end

        k = sb.key_span();
        if (k != 0)
            repeat ($urandom_range(0, 4)) doc_q.push_back(8'($urandom_range(1, 255)));
        for (int i = 0; i < k; i++) doc_q.push_back(sb.key_at(i));
        repeat ($urandom_range(0, 2)) doc_q.push_back(stop_chars[$urandom_range(0, 1)]);

        // key without a colon
        if (kind == 1) begin
            if ($urandom_range(0, 1) != 0)
                doc_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            return;
        end

        doc_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) doc_q.push_back(stop_chars[$urandom_range(0, 1)]);
        if (vlen < 0)
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
        quoted = 1'($urandom_range(0, 1));
        if (quoted) doc_q.push_back(CH_QUOTE);
        repeat (vlen) doc_q.push_back(value_byte(quoted));
        // closing byte, sometimes left off
        if ($urandom_range(0, 4) != 0)
            doc_q.push_back(quoted ? CH_QUOTE : stop_chars[$urandom_range(0, 6)]);
        repeat ($urandom_range(0, 3)) doc_q.push_back(8'($urandom_range(1, 255)));
    endtask

    task random_config(input int phase_no);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  b;
        int          zero_at;
        int          klen;
        int          blen;
        // key bytes, occasionally with a zero byte that can never match
        zero_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : -1;
        for (int i = 0; i < 16; i++) begin
            b = (i == zero_at) ? 8'h00 : 8'($urandom_range(1, 255));
            if (i < 8) lo[8*i +: 8] = b;
            else hi[8*(i-8) +: 8] = b;
        end
        case ($urandom_range(0, 7))
            0: klen = 0;
            1: klen = 16;
            2: klen = $urandom_range(17, 31);
            default: klen = $urandom_range(1, 15);
        endcase
        case ($urandom_range(0, 7))
            0: blen = 0;
            1: blen = 64;
            2: blen = $urandom_range(65, 127);
            3: blen = 1;
            default: blen = $urandom_range(2, 63);
        endcase
        // first phase: full-width key and full buffer for the long value
        if (phase_no == 0) begin
            zero_at = -1;
            for (int i = 0; i < 16; i++) begin
                b = 8'($urandom_range(1, 255));
                if (i < 8) lo[8*i +: 8] = b;
                else hi[8*(i-8) +: 8] = b;
            end
            klen = 16;
            blen = 64;
        end
        configure(lo, hi, klen, blen);
    endtask

    initial begin
        int phase_no;
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_KEY_LOW;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_m_axis_tready <= 1'b0;
        stall_mode      <= 0;
        stall_tick      <= 8'h00;
        burst_left  = $urandom_range(0, 30);
        n_doc_bytes = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key is a single zero byte: never matches
        send_doc_str("a");

        idle_sender();
        wait_drained();
        configure(64'h6B, 64'h0, 1, 64);
        stall_mode <= 1;
        send_doc_str("");              // empty document
        send_doc_str("k:v");           // bare value ended by end of document
        send_doc_str("k\t: \"a\"x");   // blanks, quoted value, trailing byte
        send_doc_str("kx");            // colon missing
        send_doc_str("k:}");           // terminator right after colon
        send_doc_str("k:");            // document ends after colon
        send_doc_str("\377k:\377");    // all-ones bytes

        // empty key matches at the start; buffer of one takes only empty values
        idle_sender();
        wait_drained();
        configure(64'h0, 64'h0, 0, 1);
        send_doc_str(":");
        send_doc_str(":z");

        // first phase fills the value store; later phases are random
        phase_no = 0;
        while (phase_no < 2 || n_doc_bytes < 120) begin
            idle_sender();
            wait_drained();
            random_config(phase_no);
            stall_mode <= $urandom_range(0, 3);
            if (phase_no == 0) begin
                build_doc(63);
                send_doc();
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    build_doc(-1);
                    send_doc();
                end
            end
            phase_no++;
        end

        idle_sender();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
